// ----- rtl/gmeb_pkg.sv -----
// ----------------------------------------------------------------------------
// gmeb_pkg
// Shared widths, codes and defaults of the grid median elevation binner.
// ----------------------------------------------------------------------------
`default_nettype none

package gmeb_pkg;

  localparam int MAX_GRID_WIDTH_DEF   = 64;
  localparam int MAX_GRID_HEIGHT_DEF  = 64;
  localparam int SAMPLES_PER_CELL_DEF = 16;

  localparam int COORD_W  = 24;
  localparam int RES_W    = 16;
  localparam int GDIM_W   = 7;
  localparam int MINP_W   = 16;
  localparam int MAXV_W   = 40;
  localparam int MODE_W   = 2;
  localparam int QIDX_W   = 6;
  localparam int STATUS_W = 2;
  localparam int MED_W    = COORD_W + 1;
  localparam int VAR_W    = 47;
  localparam int CNT_OUT_W = 5;
  localparam int CONF_W   = 17;
  localparam int Q16_FRAC = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MAXV_W;

  localparam logic signed [COORD_W-1:0] ORIGIN_RST = '0;
  localparam logic [RES_W-1:0]  RESOLUTION_RST = RES_W'(100);
  localparam logic [GDIM_W-1:0] GRID_DIM_RST   = GDIM_W'(64);
  localparam logic [MINP_W-1:0] MIN_POINTS_RST = MINP_W'(4);
  localparam logic [MAXV_W-1:0] MAX_VAR_RST    = MAXV_W'(10000);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_RESOLUTION = 3'd2,
    CFG_GRID_W     = 3'd3,
    CFG_GRID_H     = 3'd4,
    CFG_MIN_POINTS = 3'd5,
    CFG_MAX_VAR    = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- rtl/gmeb_if.sv -----
// ----------------------------------------------------------------------------
// gmeb_in_if / gmeb_out_if
// Valid/ready channels carrying point beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmeb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [gmeb_pkg::MODE_W-1:0]          mode;
  logic signed [gmeb_pkg::COORD_W-1:0]  x_mm;
  logic signed [gmeb_pkg::COORD_W-1:0]  y_mm;
  logic signed [gmeb_pkg::COORD_W-1:0]  z_mm;
  logic [gmeb_pkg::QIDX_W-1:0]          query_col;
  logic [gmeb_pkg::QIDX_W-1:0]          query_row;

  modport source (output valid, mode, x_mm, y_mm, z_mm, query_col, query_row,
                  input ready);
  modport sink   (input valid, mode, x_mm, y_mm, z_mm, query_col, query_row,
                  output ready);
endinterface

interface gmeb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [gmeb_pkg::STATUS_W-1:0]        status;
  logic signed [gmeb_pkg::MED_W-1:0]    median_half_mm;
  logic [gmeb_pkg::VAR_W-1:0]           variance_mm2;
  logic [gmeb_pkg::CNT_OUT_W-1:0]       height_count;
  logic [gmeb_pkg::CONF_W-1:0]          confidence_q16;

  modport source (output valid, status, median_half_mm, variance_mm2, height_count,
                  confidence_q16, input ready);
  modport sink   (input valid, status, median_half_mm, variance_mm2, height_count,
                  confidence_q16, output ready);
endinterface

`default_nettype wire

// ----- rtl/gmeb_ram.sv -----
// ----------------------------------------------------------------------------
// gmeb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gmeb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/gmeb_div.sv -----
// ----------------------------------------------------------------------------
// gmeb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gmeb_div #(
  parameter int DVD_W = 57,
  parameter int DVS_W = 47
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W:0]    shifted;
  logic              ge;

  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
    quo_d   = {quo_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/grid_median_elevation_binner.sv -----
// ----------------------------------------------------------------------------
// grid_median_elevation_binner
// Bins ground points into grid cells, answers per-cell height statistics and clears the grid.
// ----------------------------------------------------------------------------
// One beat is handled at a time; the next is taken as soon as the previous
// result sits in the output register. Cell index, variance and confidence come
// from one shared bit-serial divider of DVD_W steps (57 at default sizes); an
// add runs two divisions, a query two, plus a third when the variance exceeds
// its limit.
// Heights sit in one RAM, kept sorted; insertion moves one slot per cycle.
// Count, sum and sum of squares sit in a second RAM, cleared one cell per cycle:
// a clear beat walks all MAX_GRID_WIDTH*MAX_GRID_HEIGHT cells, and after reset
// the same pass runs before the first beat.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_median_elevation_binner #(
  parameter int MAX_GRID_WIDTH   = gmeb_pkg::MAX_GRID_WIDTH_DEF,
  parameter int MAX_GRID_HEIGHT  = gmeb_pkg::MAX_GRID_HEIGHT_DEF,
  parameter int SAMPLES_PER_CELL = gmeb_pkg::SAMPLES_PER_CELL_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [gmeb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gmeb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  gmeb_in_if.sink                              in_i,
  gmeb_out_if.source                           out_o
);

  import gmeb_pkg::*;

  localparam int NCELLS = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int NSLOTS = NCELLS * SAMPLES_PER_CELL;
  localparam int CELL_W = NCELLS > 1 ? $clog2(NCELLS) : 1;
  localparam int HA_W   = NSLOTS > 1 ? $clog2(NSLOTS) : 1;
  localparam int COL_W  = MAX_GRID_WIDTH > 1 ? $clog2(MAX_GRID_WIDTH) : 1;
  localparam int ROW_W  = MAX_GRID_HEIGHT > 1 ? $clog2(MAX_GRID_HEIGHT) : 1;
  localparam int AW_MAX = MAX_GRID_WIDTH > MAX_GRID_HEIGHT ? MAX_GRID_WIDTH
                                                           : MAX_GRID_HEIGHT;
  localparam int AW_W   = $clog2(AW_MAX + 1) > GDIM_W ? $clog2(AW_MAX + 1) : GDIM_W;
  localparam int CNT_W  = $clog2(SAMPLES_PER_CELL + 1);
  localparam int LOG_S  = $clog2(SAMPLES_PER_CELL);
  localparam int SUM_W  = COORD_W + 1 + LOG_S;
  localparam int ZSQ_W  = 2 * COORD_W - 1;
  localparam int SQ_W   = ZSQ_W + LOG_S;
  localparam int MW     = CNT_W + SUM_W + SQ_W;
  localparam int NUM_W  = SQ_W + CNT_W;
  localparam int NN_W   = 2 * CNT_W;
  localparam int PROD_W = CONF_W + MAXV_W;
  localparam int DVD_W  = NUM_W > PROD_W ? NUM_W : PROD_W;
  localparam int DVS_W  = VAR_W;

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_CLR    = 18'b000000000000000010,
    S_DIVX   = 18'b000000000000000100,
    S_DIVY   = 18'b000000000000001000,
    S_AMCHK  = 18'b000000000000010000,
    S_INS    = 18'b000000000000100000,
    S_INSW   = 18'b000000000001000000,
    S_QMCHK  = 18'b000000000010000000,
    S_QMED0  = 18'b000000000100000000,
    S_QMED1  = 18'b000000001000000000,
    S_QMUL   = 18'b000000010000000000,
    S_QSUB   = 18'b000000100000000000,
    S_QVDIV  = 18'b000001000000000000,
    S_QC1DIV = 18'b000010000000000000,
    S_QCMUL  = 18'b000100000000000000,
    S_QCST   = 18'b001000000000000000,
    S_QCDIV  = 18'b010000000000000000,
    S_OUT    = 18'b100000000000000000
  } state_e;

  // configuration
  logic signed [COORD_W-1:0] cfg_ox_q, cfg_oy_q;
  logic [RES_W-1:0]          cfg_res_q;
  logic [GDIM_W-1:0]         cfg_gw_q, cfg_gh_q;
  logic [MINP_W-1:0]         cfg_minp_q;
  logic [MAXV_W-1:0]         cfg_maxv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ox_q   <= ORIGIN_RST;
      cfg_oy_q   <= ORIGIN_RST;
      cfg_res_q  <= RESOLUTION_RST;
      cfg_gw_q   <= GRID_DIM_RST;
      cfg_gh_q   <= GRID_DIM_RST;
      cfg_minp_q <= MIN_POINTS_RST;
      cfg_maxv_q <= MAX_VAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:   cfg_ox_q   <= cfg_data_i[COORD_W-1:0];
        CFG_ORIGIN_Y:   cfg_oy_q   <= cfg_data_i[COORD_W-1:0];
        CFG_RESOLUTION: cfg_res_q  <= cfg_data_i[RES_W-1:0];
        CFG_GRID_W:     cfg_gw_q   <= cfg_data_i[GDIM_W-1:0];
        CFG_GRID_H:     cfg_gh_q   <= cfg_data_i[GDIM_W-1:0];
        CFG_MIN_POINTS: cfg_minp_q <= cfg_data_i[MINP_W-1:0];
        CFG_MAX_VAR:    cfg_maxv_q <= cfg_data_i[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  logic [AW_W-1:0]   act_w, act_h;
  logic [MINP_W-1:0] eff_minp;

  assign act_w    = (AW_W'(cfg_gw_q) > AW_W'(MAX_GRID_WIDTH)) ? AW_W'(MAX_GRID_WIDTH)
                                                               : AW_W'(cfg_gw_q);
  assign act_h    = (AW_W'(cfg_gh_q) > AW_W'(MAX_GRID_HEIGHT)) ? AW_W'(MAX_GRID_HEIGHT)
                                                                : AW_W'(cfg_gh_q);
  assign eff_minp = (cfg_minp_q == '0) ? MINP_W'(1) : cfg_minp_q;

  // state
  state_e                    state_q, state_d;
  logic [CELL_W-1:0]         clr_q, clr_d;
  logic                      clr_item_q, clr_item_d;
  logic                      out_valid_q;
  logic                      load_out;

  logic signed [COORD_W-1:0] z_q, z_d;
  logic signed [COORD_W:0]   dy_q, dy_d;
  logic [COL_W-1:0]          col_q, col_d;
  logic                      colbad_q, colbad_d;
  logic [CELL_W-1:0]         cell_q, cell_d;
  logic [CNT_W-1:0]          n_q, n_d;
  logic [CNT_W-1:0]          pos_q, pos_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [SQ_W-1:0]           sq_q, sq_d;
  logic [ZSQ_W-1:0]          zsq_q;
  logic [NUM_W-1:0]          p1_q, p1_d, p2_q, p2_d;
  logic [NN_W-1:0]           nn_q, nn_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  status_e                   st_q, st_d;
  logic signed [MED_W-1:0]   med_q, med_d;
  logic [VAR_W-1:0]          var_q, var_d;
  logic [CONF_W-1:0]         c1_q, c1_d, conf_q, conf_d;

  // arithmetic
  logic signed [COORD_W:0]     dx_w, dy_w;
  logic signed [2*COORD_W-1:0] zsq_w;
  logic [SUM_W-1:0]            smag;
  logic [2*SUM_W-1:0]          ssq_w;
  logic [NUM_W-1:0]            p1_w;
  logic [NN_W-1:0]             nn_w;
  logic [PROD_W-1:0]           prod_w;
  logic [MINP_W-1:0]           cn;

  assign dx_w   = in_i.x_mm - cfg_ox_q;
  assign dy_w   = in_i.y_mm - cfg_oy_q;
  assign zsq_w  = z_q * z_q;
  assign smag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign ssq_w  = smag * smag;
  assign p1_w   = n_q * sq_q;
  assign nn_w   = n_q * n_q;
  assign prod_w = c1_q * cfg_maxv_q;
  assign cn     = (MINP_W'(n_q) < eff_minp) ? MINP_W'(n_q) : eff_minp;

  // memories
  logic              meta_we, meta_re;
  logic [CELL_W-1:0] meta_waddr, meta_raddr;
  logic [MW-1:0]     meta_wdata, meta_rd;
  logic              hs_we, hs_re;
  logic [HA_W-1:0]   hs_waddr, hs_raddr;
  logic [COORD_W-1:0] hs_wdata, hs_rd;

  logic [CNT_W-1:0]        meta_cnt;
  logic signed [SUM_W-1:0] meta_sum;
  logic [SQ_W-1:0]         meta_sq;

  assign meta_cnt = meta_rd[MW-1 -: CNT_W];
  assign meta_sum = meta_rd[SQ_W +: SUM_W];
  assign meta_sq  = meta_rd[SQ_W-1:0];

  gmeb_ram #(.WIDTH(MW), .DEPTH(NCELLS)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rd)
  );

  gmeb_ram #(.WIDTH(COORD_W), .DEPTH(NSLOTS)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (hs_we),
    .waddr_i (hs_waddr),
    .wdata_i (hs_wdata),
    .re_i    (hs_re),
    .raddr_i (hs_raddr),
    .rdata_o (hs_rd)
  );

  // divider
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0] div_dvs;

  gmeb_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  function automatic logic [HA_W-1:0] slot_addr(logic [CELL_W-1:0] c, logic [CNT_W-1:0] s);
    return HA_W'(c) * HA_W'(SAMPLES_PER_CELL) + HA_W'(s);
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return CELL_W'(r) * CELL_W'(MAX_GRID_WIDTH) + CELL_W'(c);
  endfunction

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    logic [CELL_W-1:0] qcell;
    logic [CELL_W-1:0] acell;
    qcell = cell_addr(ROW_W'(in_i.query_row), COL_W'(in_i.query_col));
    acell = cell_addr(ROW_W'(div_quo), col_q);

    state_d    = state_q;
    clr_d      = clr_q;
    clr_item_d = clr_item_q;
    z_d        = z_q;
    dy_d       = dy_q;
    col_d      = col_q;
    colbad_d   = colbad_q;
    cell_d     = cell_q;
    n_d        = n_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    sq_d       = sq_q;
    p1_d       = p1_q;
    p2_d       = p2_q;
    nn_d       = nn_q;
    prod_d     = prod_q;
    st_d       = st_q;
    med_d      = med_q;
    var_d      = var_q;
    c1_d       = c1_q;
    conf_d     = conf_q;

    meta_we    = 1'b0;
    meta_waddr = cell_q;
    meta_wdata = {n_q + 1'b1, sum_q + SUM_W'(z_q), sq_q + SQ_W'(zsq_q)};
    meta_re    = 1'b0;
    meta_raddr = cell_q;
    hs_we      = 1'b0;
    hs_waddr   = slot_addr(cell_q, pos_q);
    hs_wdata   = z_q;
    hs_re      = 1'b0;
    hs_raddr   = slot_addr(cell_q, pos_q - 1'b1);
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    load_out   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          st_d   = ST_OK;
          med_d  = '0;
          var_d  = '0;
          n_d    = '0;
          conf_d = '0;
          z_d    = in_i.z_mm;
          dy_d   = dy_w;
          unique case (mode_e'(in_i.mode))
            MODE_ADD: begin
              if (cfg_res_q == '0 || dx_w < 0 || dy_w < 0) begin
                st_d    = ST_OUTSIDE;
                state_d = S_OUT;
              end else begin
                div_start = 1'b1;
                div_dvd   = DVD_W'($unsigned(dx_w));
                div_dvs   = DVS_W'(cfg_res_q);
                state_d   = S_DIVX;
              end
            end
            MODE_QUERY: begin
              if (AW_W'(in_i.query_col) >= act_w || AW_W'(in_i.query_row) >= act_h) begin
                st_d    = ST_OUTSIDE;
                state_d = S_OUT;
              end else begin
                cell_d     = qcell;
                meta_re    = 1'b1;
                meta_raddr = qcell;
                state_d    = S_QMCHK;
              end
            end
            MODE_CLEAR: begin
              clr_d      = '0;
              clr_item_d = 1'b1;
              state_d    = S_CLR;
            end
            MODE_NOP: state_d = S_OUT;
            default:  state_d = S_OUT;
          endcase
        end
      end
      S_CLR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == CELL_W'(NCELLS - 1)) begin
          clr_d      = '0;
          clr_item_d = 1'b0;
          state_d    = clr_item_q ? S_OUT : S_IDLE;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          colbad_d  = div_quo >= DVD_W'(act_w);
          col_d     = COL_W'(div_quo);
          div_start = 1'b1;
          div_dvd   = DVD_W'($unsigned(dy_q));
          div_dvs   = DVS_W'(cfg_res_q);
          state_d   = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          if (colbad_q || div_quo >= DVD_W'(act_h)) begin
            st_d    = ST_OUTSIDE;
            state_d = S_OUT;
          end else begin
            cell_d     = acell;
            meta_re    = 1'b1;
            meta_raddr = acell;
            state_d    = S_AMCHK;
          end
        end
      end
      S_AMCHK: begin
        n_d   = meta_cnt;
        sum_d = meta_sum;
        sq_d  = meta_sq;
        pos_d = meta_cnt;
        if (meta_cnt >= CNT_W'(SAMPLES_PER_CELL)) begin
          st_d    = ST_FULL;
          state_d = S_OUT;
        end else if (meta_cnt == '0) begin
          state_d = S_INSW;
        end else begin
          hs_re    = 1'b1;
          hs_raddr = slot_addr(cell_q, meta_cnt - 1'b1);
          state_d  = S_INS;
        end
      end
      S_INS: begin
        if ($signed(hs_rd) > z_q) begin
          hs_we    = 1'b1;
          hs_wdata = hs_rd;
          pos_d    = pos_q - 1'b1;
          if (pos_q > CNT_W'(1)) begin
            hs_re    = 1'b1;
            hs_raddr = slot_addr(cell_q, pos_q - CNT_W'(2));
          end else begin
            state_d = S_INSW;
          end
        end else begin
          state_d = S_INSW;
        end
      end
      S_INSW: begin
        hs_we   = 1'b1;
        meta_we = 1'b1;
        n_d     = n_q + 1'b1;
        st_d    = ST_OK;
        state_d = S_OUT;
      end
      S_QMCHK: begin
        if (meta_cnt == '0) begin
          st_d    = ST_EMPTY;
          state_d = S_OUT;
        end else begin
          n_d      = meta_cnt;
          sum_d    = meta_sum;
          sq_d     = meta_sq;
          hs_re    = 1'b1;
          hs_raddr = slot_addr(cell_q, meta_cnt >> 1);
          state_d  = S_QMED0;
        end
      end
      S_QMED0: begin
        if (n_q[0]) begin
          med_d   = {hs_rd, 1'b0};
          state_d = S_QMUL;
        end else begin
          med_d    = MED_W'($signed(hs_rd));
          hs_re    = 1'b1;
          hs_raddr = slot_addr(cell_q, (n_q >> 1) - 1'b1);
          state_d  = S_QMED1;
        end
      end
      S_QMED1: begin
        med_d   = med_q + MED_W'($signed(hs_rd));
        state_d = S_QMUL;
      end
      S_QMUL: begin
        p1_d    = p1_w;
        p2_d    = NUM_W'(ssq_w);
        nn_d    = nn_w;
        state_d = S_QSUB;
      end
      S_QSUB: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(p1_q - p2_q);
        div_dvs   = DVS_W'(nn_q);
        state_d   = S_QVDIV;
      end
      S_QVDIV: begin
        if (div_done) begin
          var_d     = VAR_W'(div_quo);
          div_start = 1'b1;
          div_dvd   = DVD_W'(cn) << Q16_FRAC;
          div_dvs   = DVS_W'(eff_minp);
          state_d   = S_QC1DIV;
        end
      end
      S_QC1DIV: begin
        if (div_done) begin
          c1_d = CONF_W'(div_quo);
          if (var_q <= VAR_W'(cfg_maxv_q)) begin
            conf_d  = CONF_W'(div_quo);
            state_d = S_OUT;
          end else begin
            state_d = S_QCMUL;
          end
        end
      end
      S_QCMUL: begin
        prod_d  = prod_w;
        state_d = S_QCST;
      end
      S_QCST: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod_q);
        div_dvs   = var_q;
        state_d   = S_QCDIV;
      end
      S_QCDIV: begin
        if (div_done) begin
          conf_d  = CONF_W'(div_quo);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      clr_item_q <= clr_item_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    z_q      <= z_d;
    dy_q     <= dy_d;
    col_q    <= col_d;
    colbad_q <= colbad_d;
    cell_q   <= cell_d;
    n_q      <= n_d;
    pos_q    <= pos_d;
    sum_q    <= sum_d;
    sq_q     <= sq_d;
    zsq_q    <= zsq_w[ZSQ_W-1:0];
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    nn_q     <= nn_d;
    prod_q   <= prod_d;
    st_q     <= st_d;
    med_q    <= med_d;
    var_q    <= var_d;
    c1_q     <= c1_d;
    conf_q   <= conf_d;
    if (load_out) begin
      out_o.status         <= st_q;
      out_o.median_half_mm <= med_q;
      out_o.variance_mm2   <= var_q;
      out_o.height_count   <= CNT_OUT_W'(n_q);
      out_o.confidence_q16 <= conf_q;
    end
  end

  assign out_o.valid = out_valid_q;

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVX || state_q == S_DIVY || state_q == S_QVDIV ||
                  state_q == S_QC1DIV || state_q == S_QCDIV))
    else $error("divider finished with no state waiting for it");

  a_height_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_we |-> (n_q < CNT_W'(SAMPLES_PER_CELL)))
    else $error("height write into a full cell");

  a_result_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_o.ready) |=> (state_q == S_OUT))
    else $error("result left while output register was occupied");

endmodule

`default_nettype wire
